/* sv/box_pair_query_unit_assert.svh */
// ----------------------------------------------------------------------------
// Box pair query - assertion macros
// Clocked on clk, disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef BOX_PAIR_QUERY_UNIT_ASSERT_SVH
`define BOX_PAIR_QUERY_UNIT_ASSERT_SVH

// same-cycle implication
`define BPQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BPQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/bpq_pkg.sv */
// ----------------------------------------------------------------------------
// Box pair query - package
// Field widths, per-axis and pipeline stage types, square root step.
// ----------------------------------------------------------------------------
package bpq_pkg;

  localparam int CW          = 20;              // coordinate width, Q16.4
  localparam int GW          = 20;              // per-axis gap width, unsigned
  localparam int SQW         = 2 * GW;          // squared gap width
  localparam int GSW         = 43;              // gap_squared field width
  localparam int GLW         = 22;              // gap_length field width
  localparam int RW          = SQW + 2;         // square root working width
  localparam int SQRT_STEPS  = 3;               // root bits resolved per stage
  localparam int SQRT_STAGES = 7;
  localparam int TOP_K       = SQRT_STAGES * SQRT_STEPS - 1;
  localparam int NSTAGE      = 3 + SQRT_STAGES;

  typedef logic signed [CW-1:0] coord_t;

  typedef struct packed {
    logic          ov;        // axis touches or overlaps
    logic          holds;     // A spans B on this axis
    coord_t        cut_min;
    coord_t        cut_max;
    logic [GW-1:0] gap;
    coord_t        near_a;
    coord_t        near_b;
  } axis_t;

  typedef struct packed {
    logic [RW-1:0] rem;
    logic [RW-1:0] root;
  } root_t;

  typedef struct packed {
    logic           ov;
    logic           holds;
    coord_t         cut_min_x;
    coord_t         cut_min_y;
    coord_t         cut_max_x;
    coord_t         cut_max_y;
    coord_t         near_a_x;
    coord_t         near_a_y;
    coord_t         near_b_x;
    coord_t         near_b_y;
    logic [GW-1:0]  gap_x;
    logic [GW-1:0]  gap_y;
    logic [SQW-1:0] sq_x;
    logic [SQW-1:0] sq_y;
    logic [GSW-1:0] gap_sq;
    root_t          sr;
  } pipe_t;

  // Three digit-by-digit root steps, starting at bit weight 4**first_k.
  function automatic root_t isqrt_stage(root_t s, int first_k);
    root_t         r;
    logic [RW-1:0] bitv;
    logic [RW-1:0] trial;
    r = s;
    for (int t = 0; t < SQRT_STEPS; t++) begin
      bitv  = RW'(1) << (2 * (first_k - t));
      trial = r.root + bitv;
      if (r.rem >= trial) begin
        r.rem  = r.rem - trial;
        r.root = (r.root >> 1) + bitv;
      end else begin
        r.root = r.root >> 1;
      end
    end
    return r;
  endfunction

endpackage

/* sv/bpq_query_if.sv */
// ----------------------------------------------------------------------------
// Box pair query - request channel
// Two boxes per request, valid/ready handshake.
// ----------------------------------------------------------------------------
interface bpq_query_if;
  logic            valid;
  logic            ready;
  bpq_pkg::coord_t a_min_x;
  bpq_pkg::coord_t a_min_y;
  bpq_pkg::coord_t a_max_x;
  bpq_pkg::coord_t a_max_y;
  bpq_pkg::coord_t b_min_x;
  bpq_pkg::coord_t b_min_y;
  bpq_pkg::coord_t b_max_x;
  bpq_pkg::coord_t b_max_y;

  modport source (
    output valid, a_min_x, a_min_y, a_max_x, a_max_y,
           b_min_x, b_min_y, b_max_x, b_max_y,
    input  ready
  );

  modport sink (
    input  valid, a_min_x, a_min_y, a_max_x, a_max_y,
           b_min_x, b_min_y, b_max_x, b_max_y,
    output ready
  );
endinterface

/* sv/bpq_answer_if.sv */
// ----------------------------------------------------------------------------
// Box pair query - result channel
// One result per request, valid/ready handshake.
// ----------------------------------------------------------------------------
interface bpq_answer_if;
  logic                     valid;
  logic                     ready;
  logic                     boxes_overlap;
  logic                     a_holds_b;
  bpq_pkg::coord_t          cut_min_x;
  bpq_pkg::coord_t          cut_min_y;
  bpq_pkg::coord_t          cut_max_x;
  bpq_pkg::coord_t          cut_max_y;
  logic [bpq_pkg::GSW-1:0]  gap_squared;
  logic [bpq_pkg::GLW-1:0]  gap_length;
  bpq_pkg::coord_t          near_a_x;
  bpq_pkg::coord_t          near_a_y;
  bpq_pkg::coord_t          near_b_x;
  bpq_pkg::coord_t          near_b_y;

  modport source (
    output valid, boxes_overlap, a_holds_b, cut_min_x, cut_min_y, cut_max_x,
           cut_max_y, gap_squared, gap_length, near_a_x, near_a_y,
           near_b_x, near_b_y,
    input  ready
  );

  modport sink (
    input  valid, boxes_overlap, a_holds_b, cut_min_x, cut_min_y, cut_max_x,
           cut_max_y, gap_squared, gap_length, near_a_x, near_a_y,
           near_b_x, near_b_y,
    output ready
  );
endinterface

/* sv/box_pair_query_unit.sv */
// ----------------------------------------------------------------------------
// Box pair query unit - top level
// Overlap, containment, intersection, gap distance and near points of two
// 2D boxes.
// ----------------------------------------------------------------------------
// Takes one request per cycle unless stage 1 is full and stalled, returning
// results in order. Stage 1 does the per-axis compares, stage 2 squares the
// gaps, stage 3 sums them, and stages 4 to 10 resolve the 21-bit floor
// square root three bits per stage; that root is what sets the latency.
// Every stage holds only while the stage after it is full and stalled, so
// bubbles are squeezed out; up to ten requests wait while a result stalls.
// ----------------------------------------------------------------------------
module box_pair_query_unit (
  input  logic          clk,
  input  logic          rst,
  bpq_query_if.sink     query,
  bpq_answer_if.source  answer
);

  localparam int NS = bpq_pkg::NSTAGE;

  bpq_pkg::axis_t  ax_x;
  bpq_pkg::axis_t  ax_y;
  bpq_pkg::pipe_t  stage      [1:NS];
  bpq_pkg::pipe_t  stage_next [1:NS];
  logic [NS:1]     stage_valid;
  logic [NS-1:0]   stage_feed;
  logic [NS+1:1]   advance;

  bpq_axis u_axis_x (
    .amin (query.a_min_x),
    .amax (query.a_max_x),
    .bmin (query.b_min_x),
    .bmax (query.b_max_x),
    .res  (ax_x)
  );

  bpq_axis u_axis_y (
    .amin (query.a_min_y),
    .amax (query.a_max_y),
    .bmin (query.b_min_y),
    .bmax (query.b_max_y),
    .res  (ax_y)
  );

  // stage hand-off
  always_comb begin
    advance[NS+1] = answer.ready;
    for (int i = NS; i >= 1; i--) begin
      advance[i] = !stage_valid[i] || advance[i+1];
    end
  end

  assign stage_feed  = {stage_valid[NS-1:1], query.valid};
  assign query.ready = advance[1];

  always_comb begin
    stage_next[1]           = '0;
    stage_next[1].ov        = ax_x.ov && ax_y.ov;
    stage_next[1].holds     = ax_x.holds && ax_y.holds;
    if (ax_x.ov && ax_y.ov) begin
      stage_next[1].cut_min_x = ax_x.cut_min;
      stage_next[1].cut_min_y = ax_y.cut_min;
      stage_next[1].cut_max_x = ax_x.cut_max;
      stage_next[1].cut_max_y = ax_y.cut_max;
    end
    stage_next[1].near_a_x  = ax_x.near_a;
    stage_next[1].near_a_y  = ax_y.near_a;
    stage_next[1].near_b_x  = ax_x.near_b;
    stage_next[1].near_b_y  = ax_y.near_b;
    stage_next[1].gap_x     = ax_x.gap;
    stage_next[1].gap_y     = ax_y.gap;

    stage_next[2]      = stage[1];
    stage_next[2].sq_x = bpq_pkg::SQW'(stage[1].gap_x) * bpq_pkg::SQW'(stage[1].gap_x);
    stage_next[2].sq_y = bpq_pkg::SQW'(stage[1].gap_y) * bpq_pkg::SQW'(stage[1].gap_y);

    stage_next[3]         = stage[2];
    stage_next[3].gap_sq  = bpq_pkg::GSW'(stage[2].sq_x) + bpq_pkg::GSW'(stage[2].sq_y);
    stage_next[3].sr.rem  = bpq_pkg::RW'(stage[2].sq_x) + bpq_pkg::RW'(stage[2].sq_y);
    stage_next[3].sr.root = '0;

    for (int j = 0; j < bpq_pkg::SQRT_STAGES; j++) begin
      stage_next[4+j]    = stage[3+j];
      stage_next[4+j].sr = bpq_pkg::isqrt_stage(stage[3+j].sr,
                             bpq_pkg::TOP_K - bpq_pkg::SQRT_STEPS * j);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
    end else begin
      for (int i = 1; i <= NS; i++) begin
        if (advance[i]) begin
          stage_valid[i] <= stage_feed[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 1; i <= NS; i++) begin
      if (advance[i] && stage_feed[i-1]) begin
        stage[i] <= stage_next[i];
      end
    end
  end

  assign answer.valid         = stage_valid[NS];
  assign answer.boxes_overlap = stage[NS].ov;
  assign answer.a_holds_b     = stage[NS].holds;
  assign answer.cut_min_x     = stage[NS].cut_min_x;
  assign answer.cut_min_y     = stage[NS].cut_min_y;
  assign answer.cut_max_x     = stage[NS].cut_max_x;
  assign answer.cut_max_y     = stage[NS].cut_max_y;
  assign answer.gap_squared   = stage[NS].gap_sq;
  assign answer.gap_length    = stage[NS].sr.root[bpq_pkg::GLW-1:0];
  assign answer.near_a_x      = stage[NS].near_a_x;
  assign answer.near_a_y      = stage[NS].near_a_y;
  assign answer.near_b_x      = stage[NS].near_b_x;
  assign answer.near_b_y      = stage[NS].near_b_y;

`include "box_pair_query_unit_assert.svh"

  `BPQ_ASSERT_NEXT(a_req_enters, query.valid && query.ready, stage_valid[1],
    "accepted request did not enter stage 1")
  `BPQ_ASSERT_NOW(a_cut_zero, answer.valid && !answer.boxes_overlap,
    (answer.cut_min_x == '0) && (answer.cut_min_y == '0) &&
    (answer.cut_max_x == '0) && (answer.cut_max_y == '0),
    "intersection not zero for disjoint boxes")
  `BPQ_ASSERT_NOW(a_no_gap, answer.valid && answer.boxes_overlap,
    answer.gap_squared == '0, "overlapping boxes report a gap")
  `BPQ_ASSERT_NOW(a_root_floor, answer.valid,
    ((44'(answer.gap_length) * 44'(answer.gap_length)) <= 44'(answer.gap_squared)) &&
    (((44'(answer.gap_length) + 44'd1) * (44'(answer.gap_length) + 44'd1)) >
     44'(answer.gap_squared)),
    "gap_length is not the floor root")

endmodule

/* sv/bpq_axis.sv */
// ----------------------------------------------------------------------------
// Box pair query - single axis compare
// Overlap, containment, intersection span, gap and near points on one axis.
// ----------------------------------------------------------------------------
module bpq_axis (
  input  bpq_pkg::coord_t amin,
  input  bpq_pkg::coord_t amax,
  input  bpq_pkg::coord_t bmin,
  input  bpq_pkg::coord_t bmax,
  output bpq_pkg::axis_t  res
);

  logic                       a_beyond;
  logic                       b_beyond;
  logic signed [bpq_pkg::CW:0] diff_a;
  logic signed [bpq_pkg::CW:0] diff_b;
  logic signed [bpq_pkg::CW:0] mid_sum;
  bpq_pkg::coord_t            mid;

  assign a_beyond = amin > bmax;
  assign b_beyond = bmin > amax;
  assign diff_a   = {amin[bpq_pkg::CW-1], amin} - {bmax[bpq_pkg::CW-1], bmax};
  assign diff_b   = {bmin[bpq_pkg::CW-1], bmin} - {amax[bpq_pkg::CW-1], amax};
  assign mid_sum  = (bmin >= amin)
                  ? {amax[bpq_pkg::CW-1], amax} + {bmin[bpq_pkg::CW-1], bmin}
                  : {amin[bpq_pkg::CW-1], amin} + {bmax[bpq_pkg::CW-1], bmax};
  // floor halving
  assign mid      = mid_sum[bpq_pkg::CW:1];

  always_comb begin
    res.ov      = !a_beyond && !b_beyond;
    res.holds   = (amin <= bmin) && (amax >= bmax);
    res.cut_min = (amin > bmin) ? amin : bmin;
    res.cut_max = (amax < bmax) ? amax : bmax;
    if (a_beyond) begin
      res.gap    = diff_a[bpq_pkg::GW-1:0];
      res.near_a = amin;
      res.near_b = bmax;
    end else if (b_beyond) begin
      res.gap    = diff_b[bpq_pkg::GW-1:0];
      res.near_a = amax;
      res.near_b = bmin;
    end else begin
      res.gap    = '0;
      res.near_a = mid;
      res.near_b = mid;
    end
  end

endmodule

/* sim/box_pair_query_unit_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Box pair query unit - testbench
// Streams box pairs through the unit and checks each result against a
// behavioural prediction of overlap, containment, intersection, gap and
// near points, under several patterns of idling and back-pressure.
// ----------------------------------------------------------------------------
module box_pair_query_unit_tb;

  localparam int MIN_C = -524288;
  localparam int MAX_C = 524287;

  typedef struct packed {
    bpq_pkg::coord_t a_min_x;
    bpq_pkg::coord_t a_min_y;
    bpq_pkg::coord_t a_max_x;
    bpq_pkg::coord_t a_max_y;
    bpq_pkg::coord_t b_min_x;
    bpq_pkg::coord_t b_min_y;
    bpq_pkg::coord_t b_max_x;
    bpq_pkg::coord_t b_max_y;
  } box_pair_t;

  typedef struct packed {
    logic                    boxes_overlap;
    logic                    a_holds_b;
    bpq_pkg::coord_t         cut_min_x;
    bpq_pkg::coord_t         cut_min_y;
    bpq_pkg::coord_t         cut_max_x;
    bpq_pkg::coord_t         cut_max_y;
    logic [bpq_pkg::GSW-1:0] gap_squared;
    logic [bpq_pkg::GLW-1:0] gap_length;
    bpq_pkg::coord_t         near_a_x;
    bpq_pkg::coord_t         near_a_y;
    bpq_pkg::coord_t         near_b_x;
    bpq_pkg::coord_t         near_b_y;
  } pair_answer_t;

  logic clk;
  logic rst;

  bpq_query_if  query_ch ();
  bpq_answer_if answer_ch ();

  box_pair_query_unit u_dut (
    .clk    (clk),
    .rst    (rst),
    .query  (query_ch),
    .answer (answer_ch)
  );

  pair_answer_t pending_answers[$];
  int           fail_count;
  int           send_idle_pct;
  int           recv_stall_pct;
  int           hold_request;
  int           hold_left;

  initial begin
    clk = 1'b0;
  end

  always #4 clk = ~clk;

  initial begin
    #4_000_000;
    $display("box_pair_query_unit_tb NOT OK");
    $finish;
  end

  // ---------------------------------------------------------------- predictor
  function automatic longint floor_root(longint v);
    longint r;
    longint t;
    r = 0;
    for (int b = bpq_pkg::GLW - 1; b >= 0; b--) begin
      t = r | (longint'(1) << b);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  function automatic void near_axis(input longint lo_a, hi_a, lo_b, hi_b,
                                    output longint gap, pa, pb);
    gap = 0;
    if (lo_a > hi_b) begin
      gap = lo_a - hi_b;
      pa  = lo_a;
      pb  = hi_b;
    end else if (lo_b > hi_a) begin
      gap = lo_b - hi_a;
      pa  = hi_a;
      pb  = lo_b;
    end else begin
      pa = (lo_b >= lo_a) ? (hi_a + lo_b) >>> 1 : (lo_a + hi_b) >>> 1;
      pb = pa;
    end
  endfunction

  function automatic pair_answer_t predict_answer(box_pair_t p);
    pair_answer_t r;
    longint ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
    longint gx, gy, pax, pay, pbx, pby, sq;
    ax0 = p.a_min_x; ay0 = p.a_min_y; ax1 = p.a_max_x; ay1 = p.a_max_y;
    bx0 = p.b_min_x; by0 = p.b_min_y; bx1 = p.b_max_x; by1 = p.b_max_y;
    r = '0;
    r.boxes_overlap = !(ax0 > bx1 || ay0 > by1 || ax1 < bx0 || ay1 < by0);
    r.a_holds_b     = !(ax0 > bx0 || ay0 > by0 || ax1 < bx1 || ay1 < by1);
    if (r.boxes_overlap) begin
      r.cut_min_x = bpq_pkg::coord_t'((ax0 > bx0) ? ax0 : bx0);
      r.cut_min_y = bpq_pkg::coord_t'((ay0 > by0) ? ay0 : by0);
      r.cut_max_x = bpq_pkg::coord_t'((ax1 < bx1) ? ax1 : bx1);
      r.cut_max_y = bpq_pkg::coord_t'((ay1 < by1) ? ay1 : by1);
    end
    near_axis(ax0, ax1, bx0, bx1, gx, pax, pbx);
    near_axis(ay0, ay1, by0, by1, gy, pay, pby);
    sq = gx * gx + gy * gy;
    r.gap_squared = bpq_pkg::GSW'(sq);
    r.gap_length  = bpq_pkg::GLW'(floor_root(sq));
    r.near_a_x    = bpq_pkg::coord_t'(pax);
    r.near_a_y    = bpq_pkg::coord_t'(pay);
    r.near_b_x    = bpq_pkg::coord_t'(pbx);
    r.near_b_y    = bpq_pkg::coord_t'(pby);
    return r;
  endfunction

  // ---------------------------------------------------------------- stimulus
  function automatic box_pair_t make_pair(int ax0, ay0, ax1, ay1,
                                          int bx0, by0, bx1, by1);
    box_pair_t p;
    p.a_min_x = bpq_pkg::coord_t'(ax0); p.a_min_y = bpq_pkg::coord_t'(ay0);
    p.a_max_x = bpq_pkg::coord_t'(ax1); p.a_max_y = bpq_pkg::coord_t'(ay1);
    p.b_min_x = bpq_pkg::coord_t'(bx0); p.b_min_y = bpq_pkg::coord_t'(by0);
    p.b_max_x = bpq_pkg::coord_t'(bx1); p.b_max_y = bpq_pkg::coord_t'(by1);
    return p;
  endfunction

  // span 0 means the whole field
  function automatic int pick_coord(int span);
    bpq_pkg::coord_t c;
    if (span == 0) begin
      c = bpq_pkg::coord_t'($urandom);
      return int'(c);
    end
    return int'($urandom_range(0, 2 * span - 1)) - span;
  endfunction

  function automatic void pick_range(input int span, output int lo, hi);
    int u;
    int v;
    u  = pick_coord(span);
    v  = pick_coord(span);
    lo = (u < v) ? u : v;
    hi = (u < v) ? v : u;
  endfunction

  function automatic int pick_between(int lo, int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  function automatic box_pair_t random_pair();
    int spans[4] = '{0, 65536, 256, 16};
    int span;
    int kind;
    int ax0, ay0, ax1, ay1, bx0, by0, bx1, by1, t;
    span = spans[$urandom_range(0, 3)];
    kind = $urandom_range(0, 99);
    pick_range(span, ax0, ax1);
    pick_range(span, ay0, ay1);
    if (kind < 10) begin
      // noise: corners in any order
      ax0 = pick_coord(span); ax1 = pick_coord(span);
      ay0 = pick_coord(span); ay1 = pick_coord(span);
      bx0 = pick_coord(span); bx1 = pick_coord(span);
      by0 = pick_coord(span); by1 = pick_coord(span);
    end else if (kind < 30) begin
      bx0 = pick_between(ax0, ax1); bx1 = pick_between(bx0, ax1);
      by0 = pick_between(ay0, ay1); by1 = pick_between(by0, ay1);
    end else if (kind < 40) begin
      // shared or touching edges
      bx0 = ($urandom_range(0, 1) != 0) ? ax1 : ax0;
      by0 = ($urandom_range(0, 1) != 0) ? ay1 : ay0;
      bx1 = pick_between(bx0, MAX_C);
      by1 = pick_between(by0, MAX_C);
    end else begin
      pick_range(span, bx0, bx1);
      pick_range(span, by0, by1);
    end
    if ($urandom_range(0, 1) != 0) begin
      t = ax0; ax0 = bx0; bx0 = t;
      t = ax1; ax1 = bx1; bx1 = t;
      t = ay0; ay0 = by0; by0 = t;
      t = ay1; ay1 = by1; by1 = t;
    end
    return make_pair(ax0, ay0, ax1, ay1, bx0, by0, bx1, by1);
  endfunction

  task automatic send_request(box_pair_t p);
    while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      query_ch.valid <= 1'b0;
      @(posedge clk);
    end
    query_ch.valid   <= 1'b1;
    query_ch.a_min_x <= p.a_min_x;
    query_ch.a_min_y <= p.a_min_y;
    query_ch.a_max_x <= p.a_max_x;
    query_ch.a_max_y <= p.a_max_y;
    query_ch.b_min_x <= p.b_min_x;
    query_ch.b_min_y <= p.b_min_y;
    query_ch.b_max_x <= p.b_max_x;
    query_ch.b_max_y <= p.b_max_y;
    do @(posedge clk); while (!query_ch.ready);
    pending_answers.push_back(predict_answer(p));
  endtask

  task automatic wait_all_answered();
    query_ch.valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------- results
  always @(posedge clk) begin
    if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      answer_ch.ready <= 1'b0;
      hold_left--;
    end else begin
      answer_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    pair_answer_t w;
    if (!rst && answer_ch.valid && answer_ch.ready) begin
      if (pending_answers.size() == 0) begin
        $display("%0t: result with no request outstanding", $time);
        fail_count++;
      end else begin
        w = pending_answers.pop_front();
        check_field("boxes_overlap", w.boxes_overlap, answer_ch.boxes_overlap);
        check_field("a_holds_b", w.a_holds_b, answer_ch.a_holds_b);
        check_field("cut_min_x", w.cut_min_x, answer_ch.cut_min_x);
        check_field("cut_min_y", w.cut_min_y, answer_ch.cut_min_y);
        check_field("cut_max_x", w.cut_max_x, answer_ch.cut_max_x);
        check_field("cut_max_y", w.cut_max_y, answer_ch.cut_max_y);
        check_field("gap_squared", w.gap_squared, answer_ch.gap_squared);
        check_field("gap_length", w.gap_length, answer_ch.gap_length);
        check_field("near_a_x", w.near_a_x, answer_ch.near_a_x);
        check_field("near_a_y", w.near_a_y, answer_ch.near_a_y);
        check_field("near_b_x", w.near_b_x, answer_ch.near_b_x);
        check_field("near_b_y", w.near_b_y, answer_ch.near_b_y);
      end
    end
  end

  // ---------------------------------------------------------------- tests
  task automatic test_corner_cases();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_request(make_pair(MIN_C, MIN_C, MIN_C, MIN_C, MIN_C, MIN_C, MIN_C, MIN_C));
    send_request(make_pair(MAX_C, MAX_C, MAX_C, MAX_C, MAX_C, MAX_C, MAX_C, MAX_C));
    send_request(make_pair(MIN_C, MIN_C, MAX_C, MAX_C, MIN_C, MIN_C, MAX_C, MAX_C));
    send_request(make_pair(MIN_C, MIN_C, MAX_C, MAX_C, 0, 0, 16, 16));
    send_request(make_pair(0, 0, 16, 16, -32, -32, 48, 48));
    // inclusive touching on an edge and on a corner
    send_request(make_pair(0, 0, 10, 10, 10, 0, 20, 10));
    send_request(make_pair(0, 0, 10, 10, 10, 10, 20, 20));
    send_request(make_pair(0, 0, 10, 10, 11, 0, 20, 10));
    send_request(make_pair(0, 0, 10, 10, 0, -20, 10, -1));
    send_request(make_pair(0, 0, 10, 10, -30, 40, -5, 50));
    send_request(make_pair(0, 0, 10, 10, 100, 5, 200, 8));
    // widest gaps both ways
    send_request(make_pair(MAX_C, MAX_C, MAX_C, MAX_C, MIN_C, MIN_C, MIN_C, MIN_C));
    send_request(make_pair(MIN_C, MIN_C, MIN_C, MIN_C, MAX_C, MAX_C, MAX_C, MAX_C));
    // odd negative midpoint sums round down
    send_request(make_pair(-3, -5, 4, -1, -8, -2, -2, 3));
    send_request(make_pair(-5, -3, -1, 4, -2, -8, 3, -2));
    // boxes with min above max
    send_request(make_pair(10, 5, -10, -5, 0, 0, 0, 0));
    send_request(make_pair(0, 0, 0, 0, 20, 30, -20, -30));
    send_request(make_pair(MAX_C, MAX_C, MIN_C, MIN_C, MAX_C, MAX_C, MIN_C, MIN_C));
    send_request(make_pair(7, -9, 33, 12, 7, -9, 33, 12));
    send_request(make_pair(-1, -1, -1, -1, -1, -1, -1, -1));
    send_request(make_pair(-349526, -349526, 349525, 349525,
                           349525, -349526, -349526, 349525));
    wait_all_answered();
  endtask

  task automatic test_random_traffic(int send_pct, int recv_pct, int count);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    repeat (count) send_request(random_pair());
  endtask

  task automatic test_input_stall();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_request   = 300;
    repeat (120) send_request(random_pair());
  endtask

  task automatic test_drain_pause();
    send_idle_pct  = 16;
    recv_stall_pct = 16;
    repeat (40) send_request(random_pair());
    wait_all_answered();
    repeat (40) send_request(random_pair());
  endtask

  initial begin
    rst              = 1'b1;
    fail_count       = 0;
    send_idle_pct    = 0;
    recv_stall_pct   = 0;
    hold_request     = 0;
    hold_left        = 0;
    query_ch.valid   = 1'b0;
    query_ch.a_min_x = '0;
    query_ch.a_min_y = '0;
    query_ch.a_max_x = '0;
    query_ch.a_max_y = '0;
    query_ch.b_min_x = '0;
    query_ch.b_min_y = '0;
    query_ch.b_max_x = '0;
    query_ch.b_max_y = '0;
    answer_ch.ready  = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_corner_cases();
    test_random_traffic(0, 0, 420);
    test_random_traffic(48, 0, 420);
    test_random_traffic(0, 48, 420);
    test_random_traffic(16, 16, 420);
    test_input_stall();
    test_drain_pause();

    wait_all_answered();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("box_pair_query_unit_tb OK");
    end else begin
      $display("box_pair_query_unit_tb NOT OK");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+sv
sv/bpq_pkg.sv
sv/bpq_query_if.sv
sv/bpq_answer_if.sv
sv/bpq_axis.sv
sv/box_pair_query_unit.sv
sim/box_pair_query_unit_tb.sv
